FILE: sv/sit_pkg.sv
// Shared constants and types for the segment intersection test unit.
package sit_pkg;

  // Default coordinate width, in bits, two's complement.
  localparam int COORD_WIDTH_DEF = 16;

  // Load enables for the two register stages of a split multiplier.
  typedef struct packed {
    logic load_a;
    logic load_b;
  } sit_mul_ctl_t;

endpackage

FILE: sv/sit_wide_mul.sv
// Two-stage signed multiplier that splits its wide operand into two halves.
module sit_wide_mul #(
  parameter int AW = 17,
  parameter int BW = 33
) (
  input  logic                       clk,
  input  sit_pkg::sit_mul_ctl_t      ctl,
  input  logic signed [AW-1:0]       a,
  input  logic signed [BW-1:0]       b,
  output logic signed [AW+BW-1:0]    p
);
  import sit_pkg::*;

  localparam int BLO = (BW + 2) / 2;
  localparam int BHW = BW - BLO;
  localparam int PLW = AW + BLO + 1;
  localparam int PHW = AW + BHW;
  localparam int PW  = AW + BW;

  logic signed [BLO:0]   b_lo;
  logic signed [BHW-1:0] b_hi;
  logic signed [PLW-1:0] p_lo;
  logic signed [PHW-1:0] p_hi;

  // The low half is taken as a positive number, the high half keeps the sign.
  assign b_lo = $signed({1'b0, b[BLO-1:0]});
  assign b_hi = $signed(b[BW-1:BLO]);

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      p_lo <= PLW'(a) * PLW'(b_lo);
      p_hi <= PHW'(a) * PHW'(b_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      p <= (PW'(p_hi) <<< BLO) + PW'(p_lo);
    end
  end

endmodule

FILE: sv/segment_intersection_test_unit.sv
// Top level of the segment intersection test unit.
// Each input beat carries two segments, (ax,ay)-(bx,by_coord) and (cx,cy)-(dx,dy).
// Each output beat carries crosses: 1 when the crossing point of the two lines
// lies inside both segments' bounding boxes, bounds included. Parallel,
// collinear or degenerate segments give 0.
// Both channels use valid and stall; a beat moves on an edge with valid high
// and stall low. Results come out in input order, one per input beat.
// Throughput is one beat per cycle while the receiver does not stall, set by
// a six-stage pipeline whose widest steps are the split numerator and bound
// multiplications; the result is shown from the register of the last stage.
// When the receiver stalls, the shown result holds and empty stages still
// fill, so input is taken until all six stages are full.
// Reset empties the pipeline; no item in flight survives it.
module segment_intersection_test_unit #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by_coord,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] dx,
  input  logic signed [COORD_WIDTH-1:0] dy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          crosses
);
  import sit_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;        // endpoint difference
  localparam int RPW  = 2 * CW;        // coordinate product
  localparam int CFW  = 2 * CW + 1;    // line constant
  localparam int MW   = 2 * CW + 2;    // difference product
  localparam int DENW = 2 * CW + 3;    // denominator
  localparam int NTW  = DW + CFW;      // numerator term
  localparam int NW   = NTW + 1;       // numerator
  localparam int BPW  = CW + DENW;     // bound times denominator

  // True when n lies between the two bounds, in either order, inclusive.
  function automatic logic in_span(input logic signed [NW-1:0] n,
                                   input logic signed [BPW-1:0] p,
                                   input logic signed [BPW-1:0] q);
    return (p <= n && n <= q) || (q <= n && n <= p);
  endfunction

  // Stage valid bits and the ready chain.
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  assign rdy6 = !v6 || !out_stall;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign ld1 = rdy1 && in_valid;
  assign ld2 = rdy2 && v1;
  assign ld3 = rdy3 && v2;
  assign ld4 = rdy4 && v3;
  assign ld5 = rdy5 && v4;
  assign ld6 = rdy6 && v5;

  assign in_stall  = !rdy1;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // Endpoints in the order ax, ay, bx, by_coord, cx, cy, dx, dy.
  logic signed [CW-1:0] pt_in [8];
  logic signed [CW-1:0] s1_pt [8];
  logic signed [CW-1:0] s2_pt [8];
  logic signed [CW-1:0] s3_pt [8];

  assign pt_in[0] = ax;
  assign pt_in[1] = ay;
  assign pt_in[2] = bx;
  assign pt_in[3] = by_coord;
  assign pt_in[4] = cx;
  assign pt_in[5] = cy;
  assign pt_in[6] = dx;
  assign pt_in[7] = dy;

  // Stage 1: endpoint differences and the cross products of the endpoints.
  logic signed [DW-1:0]  s1_ex1, s1_ey1, s1_ex2, s1_ey2;
  logic signed [RPW-1:0] s1_pr [4];

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_pt    <= pt_in;
      s1_ex1   <= DW'(ax) - DW'(bx);
      s1_ey1   <= DW'(ay) - DW'(by_coord);
      s1_ex2   <= DW'(cx) - DW'(dx);
      s1_ey2   <= DW'(cy) - DW'(dy);
      s1_pr[0] <= RPW'(ax) * RPW'(by_coord);
      s1_pr[1] <= RPW'(ay) * RPW'(bx);
      s1_pr[2] <= RPW'(cx) * RPW'(dy);
      s1_pr[3] <= RPW'(cy) * RPW'(dx);
    end
  end

  // Stage 2: line constants and the two halves of the denominator.
  logic signed [DW-1:0]  s2_ex1, s2_ey1, s2_ex2, s2_ey2;
  logic signed [CFW-1:0] s2_c1, s2_c2;
  logic signed [MW-1:0]  s2_ma, s2_mb;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_pt  <= s1_pt;
      s2_ex1 <= s1_ex1;
      s2_ey1 <= s1_ey1;
      s2_ex2 <= s1_ex2;
      s2_ey2 <= s1_ey2;
      s2_c1  <= CFW'(s1_pr[0]) - CFW'(s1_pr[1]);
      s2_c2  <= CFW'(s1_pr[2]) - CFW'(s1_pr[3]);
      s2_ma  <= MW'(s1_ex1) * MW'(s1_ey2);
      s2_mb  <= MW'(s1_ey1) * MW'(s1_ex2);
    end
  end

  // Stage 3: denominator. The numerator terms are multiplied over stages 3 and 4.
  logic signed [DENW-1:0] s3_den;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_pt  <= s2_pt;
      s3_den <= DENW'(s2_ma) - DENW'(s2_mb);
    end
  end

  logic signed [DW-1:0]  nm_a [4];
  logic signed [CFW-1:0] nm_b [4];
  logic signed [NTW-1:0] s4_t [4];
  sit_mul_ctl_t          nm_ctl;

  // Terms: c1*ex2, ex1*c2, c1*ey2, ey1*c2.
  assign nm_a[0] = s2_ex2;
  assign nm_b[0] = s2_c1;
  assign nm_a[1] = s2_ex1;
  assign nm_b[1] = s2_c2;
  assign nm_a[2] = s2_ey2;
  assign nm_b[2] = s2_c1;
  assign nm_a[3] = s2_ey1;
  assign nm_b[3] = s2_c2;

  assign nm_ctl.load_a = ld3;
  assign nm_ctl.load_b = ld4;

  for (genvar i = 0; i < 4; i++) begin : g_num
    sit_wide_mul #(
      .AW (DW),
      .BW (CFW)
    ) u_mul (
      .clk (clk),
      .ctl (nm_ctl),
      .a   (nm_a[i]),
      .b   (nm_b[i]),
      .p   (s4_t[i])
    );
  end

  // Stage 4: denominator carried on; each endpoint times the denominator
  // is multiplied over stages 4 and 5.
  logic signed [DENW-1:0] s4_den;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_den <= s3_den;
    end
  end

  logic signed [BPW-1:0] s5_bd [8];
  sit_mul_ctl_t          bd_ctl;

  assign bd_ctl.load_a = ld4;
  assign bd_ctl.load_b = ld5;

  for (genvar i = 0; i < 8; i++) begin : g_bound
    sit_wide_mul #(
      .AW (CW),
      .BW (DENW)
    ) u_mul (
      .clk (clk),
      .ctl (bd_ctl),
      .a   (s3_pt[i]),
      .b   (s3_den),
      .p   (s5_bd[i])
    );
  end

  // Stage 5: numerators.
  logic signed [NW-1:0] s5_nx, s5_ny;
  logic                 s5_den_nz;

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_nx     <= NW'(s4_t[0]) - NW'(s4_t[1]);
      s5_ny     <= NW'(s4_t[2]) - NW'(s4_t[3]);
      s5_den_nz <= (s4_den != '0);
    end
  end

  // Stage 6: each numerator must lie between the scaled ends of both segments.
  // Comparing against both scaled ends in either order covers a negative
  // denominator without negating anything.
  logic hit;

  assign hit = s5_den_nz &&
               in_span(s5_nx, s5_bd[0], s5_bd[2]) &&
               in_span(s5_nx, s5_bd[4], s5_bd[6]) &&
               in_span(s5_ny, s5_bd[1], s5_bd[3]) &&
               in_span(s5_ny, s5_bd[5], s5_bd[7]);

  always_ff @(posedge clk) begin
    if (ld6) begin
      crosses <= hit;
    end
  end

  // A zero denominator can never produce a crossing.
  a_zero_den_no_hit : assert property (@(posedge clk) disable iff (rst)
    (ld6 && !s5_den_nz) |=> !crosses)
    else $error("crossing reported for a zero denominator");

  // Input is refused only when every stage is full and the output is stalled.
  a_stall_only_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && v5 && v6 && out_stall))
    else $error("input stalled while the pipeline has room");

  // A result moves into an empty output stage on the next edge.
  a_no_lost_item : assert property (@(posedge clk) disable iff (rst)
    (v5 && !v6) |=> v6)
    else $error("item in stage five did not advance");

  // A taken result with nothing behind it leaves the output empty.
  a_no_repeat : assert property (@(posedge clk) disable iff (rst)
    (v6 && !out_stall && !v5) |=> !v6)
    else $error("result repeated after it was taken");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the segment intersection test unit.
`timescale 1ns / 1ps

module tb_top;

  import sit_pkg::*;

  localparam int COORD_W = COORD_WIDTH_DEF;
  localparam int N_RANDOM = 932;
  localparam int DRAIN_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [127:0] acc_t;

  typedef enum logic [1:0] {
    VERDICT_MODEL,
    VERDICT_NO,
    VERDICT_YES
  } verdict_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } seg_pair_t;

  typedef struct packed {
    seg_pair_t pair;
    verdict_t  want;
  } dir_row_t;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  coord_t ax, ay, bx, by_coord, cx, cy, dx, dy;
  logic   out_valid;
  logic   out_stall;
  logic   crosses;

  bit crossing_q[$];
  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int hit_count = 0;

  // Hand-picked pairs; the verdict is typed in only where it is obvious.
  dir_row_t dir_rows [18] = '{
    // All ends at the origin: both segments degenerate.
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, VERDICT_NO},
    // Plain X through the origin.
    '{'{-16'sd10, -16'sd10, 16'sd10, 16'sd10, -16'sd10, 16'sd10, 16'sd10, -16'sd10},
      VERDICT_YES},
    // Parallel horizontal lines.
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd5, 16'sd10, 16'sd5}, VERDICT_NO},
    // Collinear and overlapping still gives no crossing.
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd5, 16'sd5, 16'sd15, 16'sd15}, VERDICT_NO},
    // First segment collapsed to a point lying on the second one.
    '{'{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd10, 16'sd10}, VERDICT_NO},
    // Second segment touches the end of the first: bounds are included.
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd10, -16'sd5, 16'sd10, 16'sd5}, VERDICT_YES},
    // Lines cross well beyond the first segment.
    '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd5, -16'sd5, 16'sd5, 16'sd5}, VERDICT_NO},
    // Full-range diagonals cross at (-0.5, -0.5).
    '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
        16'sh8000}, VERDICT_YES},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        16'sh7FFF}, VERDICT_NO},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000}, VERDICT_NO},
    // Full-range axes.
    '{'{16'sh8000, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sh7FFF},
      VERDICT_YES},
    // X with reversed end order, flipping the sign of the denominator.
    '{'{16'sd10, 16'sd10, -16'sd10, -16'sd10, -16'sd10, 16'sd10, 16'sd10, -16'sd10},
      VERDICT_YES},
    // One unit short of touching.
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd11, -16'sd5, 16'sd11, 16'sd5}, VERDICT_NO},
    '{'{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555, 16'sh5555, 16'shAAAA,
        16'shAAAA}, VERDICT_MODEL},
    // Crossing at a fractional y just inside, then just outside.
    '{'{16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd1, 16'sd0, 16'sd1, 16'sd5}, VERDICT_MODEL},
    '{'{16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd5}, VERDICT_MODEL},
    '{'{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
        16'sh7FFF}, VERDICT_MODEL},
    // Collinear at the extremes.
    '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 16'sh7FFF,
        16'sh7FFF}, VERDICT_NO}
  };

  segment_intersection_test_unit #(
    .COORD_WIDTH(COORD_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ax       (ax),
    .ay       (ay),
    .bx       (bx),
    .by_coord (by_coord),
    .cx       (cx),
    .cy       (cy),
    .dx       (dx),
    .dy       (dy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .crosses  (crosses)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit in_span(acc_t p, acc_t q, acc_t num, acc_t den);
    acc_t lo, hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    return (lo * den <= num) && (num <= hi * den);
  endfunction

  // Crossing point of the two lines is (nx/den, ny/den); bounds are checked
  // by cross-multiplying with a positive denominator.
  function automatic bit crossing_in_boxes(seg_pair_t s);
    acc_t x1, y1, x2, y2, x3, y3, x4, y4;
    acc_t c1, c2, ex1, ey1, ex2, ey2, den, nx, ny;
    x1 = acc_t'(s.ax);
    y1 = acc_t'(s.ay);
    x2 = acc_t'(s.bx);
    y2 = acc_t'(s.by_coord);
    x3 = acc_t'(s.cx);
    y3 = acc_t'(s.cy);
    x4 = acc_t'(s.dx);
    y4 = acc_t'(s.dy);
    c1 = x1 * y2 - y1 * x2;
    c2 = x3 * y4 - y3 * x4;
    ex1 = x1 - x2;
    ey1 = y1 - y2;
    ex2 = x3 - x4;
    ey2 = y3 - y4;
    den = ex1 * ey2 - ey1 * ex2;
    nx = c1 * ex2 - ex1 * c2;
    ny = c1 * ey2 - ey1 * c2;
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      nx = -nx;
      ny = -ny;
    end
    return in_span(x1, x2, nx, den) && in_span(x3, x4, nx, den) &&
           in_span(y1, y2, ny, den) && in_span(y3, y4, ny, den);
  endfunction

  function automatic int spread(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int mode, px, py, ux, uy, vx, vy, k, j;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: begin
        s = {any_coord(), any_coord(), any_coord(), any_coord(),
             any_coord(), any_coord(), any_coord(), any_coord()};
      end
      3, 4: begin
        // Small grid: many touches, parallels and shared points.
        s = {coord_t'(spread(20)), coord_t'(spread(20)), coord_t'(spread(20)),
             coord_t'(spread(20)), coord_t'(spread(20)), coord_t'(spread(20)),
             coord_t'(spread(20)), coord_t'(spread(20))};
      end
      5: begin
        px = spread(8000);
        py = spread(8000);
        ux = spread(2000);
        uy = spread(2000);
        k = $urandom_range(0, 1) ? int'($urandom_range(1, 2)) : -int'($urandom_range(1, 2));
        s.ax = coord_t'(px);
        s.ay = coord_t'(py);
        s.bx = coord_t'(px + ux);
        s.by_coord = coord_t'(py + uy);
        if ($urandom_range(0, 1)) begin
          j = spread(3);
          s.cx = coord_t'(px + j * ux);
          s.cy = coord_t'(py + j * uy);
        end else begin
          s.cx = coord_t'(px + spread(4000));
          s.cy = coord_t'(py + spread(4000));
        end
        s.dx = coord_t'(int'(s.cx) + k * ux);
        s.dy = coord_t'(int'(s.cy) + k * uy);
      end
      6: begin
        s = {any_coord(), any_coord(), any_coord(), any_coord(),
             any_coord(), any_coord(), any_coord(), any_coord()};
        if ($urandom_range(0, 1)) begin
          s.bx = s.ax;
          s.by_coord = s.ay;
        end else begin
          s.dx = s.cx;
          s.dy = s.cy;
        end
      end
      default: begin
        // Segments built around a shared lattice point; in half of the pairs the second one ends on it.
        px = spread(16000);
        py = spread(16000);
        ux = spread(16000);
        uy = spread(16000);
        vx = spread(16000);
        vy = spread(16000);
        s.ax = coord_t'(px - ux);
        s.ay = coord_t'(py - uy);
        s.bx = coord_t'(px + ux);
        s.by_coord = coord_t'(py + uy);
        if ($urandom_range(0, 1)) begin
          s.cx = coord_t'(px - vx);
          s.cy = coord_t'(py - vy);
        end else begin
          s.cx = coord_t'(px);
          s.cy = coord_t'(py);
        end
        s.dx = coord_t'(px + vx);
        s.dy = coord_t'(py + vy);
      end
    endcase
    return s;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    // Every fourth block of 64 beats goes out back to back.
    if ((sent_count / 64) % 4 == 3) return 0;
    if (r < 22) return $urandom_range(1, 3);
    if (r < 25) return $urandom_range(10, 40);
    return 0;
  endfunction

  task automatic send_pair(seg_pair_t p, bit want);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ax <= p.ax;
    ay <= p.ay;
    bx <= p.bx;
    by_coord <= p.by_coord;
    cx <= p.cx;
    cy <= p.cy;
    dx <= p.dx;
    dy <= p.dy;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    crossing_q.insert(crossing_q.size(), want);
    sent_count++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (crossing_q.size() != 0);
  endtask

  initial begin : stimulus
    seg_pair_t pair;
    bit want;
    int idx;
    int waited;
    rst <= 1'b1;
    in_valid <= 1'b0;
    ax <= '0;
    ay <= '0;
    bx <= '0;
    by_coord <= '0;
    cx <= '0;
    cy <= '0;
    dx <= '0;
    dy <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].want == VERDICT_MODEL) want = crossing_in_boxes(dir_rows[i].pair);
      else want = (dir_rows[i].want == VERDICT_YES);
      send_pair(dir_rows[i].pair, want);
    end
    drain_pipeline();

    for (idx = 0; idx < N_RANDOM; idx++) begin
      if (idx == N_RANDOM / 2) drain_pipeline();
      pair = random_pair();
      send_pair(pair, crossing_in_boxes(pair));
    end

    in_valid <= 1'b0;
    waited = 0;
    while (crossing_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // Give a stray extra beat time to show up.
    repeat (12) @(posedge clk);
    if (crossing_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", crossing_q.size());
      fail_count += crossing_q.size();
    end

    $display("Sent %0d segment pairs (%0d hand-picked), checked %0d results, %0d crossing.",
             sent_count, $size(dir_rows), checked_count, hit_count);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : result_stall
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 23) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    bit want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (crossing_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: result beat with nothing expected, crosses=%b", crosses);
      end else begin
        want = crossing_q.pop_front();
        checked_count++;
        if (want) hit_count++;
        if (crosses !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: result %0d crosses expected %b, got %b",
                     checked_count, want, crosses);
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("ERROR: run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
sv/sit_pkg.sv
sv/sit_wide_mul.sv
sv/segment_intersection_test_unit.sv
tb/tb_top.sv
